[rtl/fvn_pkg.sv]
package fvn_pkg;

  localparam int unsigned OCT_MAX    = 8;
  localparam int unsigned OCT_W      = $clog2(OCT_MAX);
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned ACC_W      = 16 + OCT_MAX + $clog2(OCT_MAX);
  localparam int unsigned PIPE_DEPTH = 8;

  localparam logic [31:0] HASH_X   = 32'd1664525;
  localparam logic [31:0] HASH_Z   = 32'd1013904223;
  localparam logic [31:0] HASH_S   = 32'd22695477;
  localparam logic [31:0] HASH_MIX = 32'h045d9f3b;

  typedef enum logic [0:0] {
    CFG_SEED   = 1'b0,
    CFG_OCTAVE = 1'b1
  } cfg_idx_t;

  // 2^32 / (2^c - 1), rounded
  function automatic logic [32:0] recip_lookup(input logic [CNT_W-1:0] c);
    logic [32:0] r;
    case (c)
      4'd1:    r = 33'h1_0000_0000;
      4'd2:    r = 33'd1431655765;
      4'd3:    r = 33'd613566757;
      4'd4:    r = 33'd286331153;
      4'd5:    r = 33'd138547332;
      4'd6:    r = 33'd68174084;
      4'd7:    r = 33'd33818640;
      4'd8:    r = 33'd16843009;
      default: r = 33'h1_0000_0000;
    endcase
    return r;
  endfunction

endpackage

[rtl/fractal_value_noise.sv]
// Fractal value noise: one Q16.16 point (x, z) in, one Q0.16 noise value out.
// All octaves up to the maximum are evaluated in parallel lanes: an input
// register, a five-stage multiply pipeline per lane and a two-stage normalizer,
// eight register stages in all, so a new point is taken every cycle while the
// output is not stalled. A stall on the output holds the whole pipeline;
// in_stall rises only while a finished beat waits at the output. Write
// noise_seed (index 0) and octave_count (index 1) while no beat is in flight;
// the count is sampled when a beat enters.
module fractal_value_noise
  import fvn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_coord,
  input  logic [31:0] in_z_coord,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_noise_value,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]           seed_r;
  logic [CNT_W-1:0]      ocnt_r, cnt_in;
  logic [PIPE_DEPTH-1:0] v_r;
  logic                  adv;
  logic [31:0]           x_r, z_r;
  logic [CNT_W-1:0]      cnt_r [PIPE_DEPTH-2];
  logic [15:0]           lane_n [OCT_MAX];

  assign adv      = !(v_r[PIPE_DEPTH-1] && out_stall);
  assign in_stall = !adv;

  always_comb begin
    cnt_in = ocnt_r;
    if (ocnt_r == '0) begin
      cnt_in = CNT_W'(1);
    end else if (ocnt_r > CNT_W'(OCT_MAX)) begin
      cnt_in = CNT_W'(OCT_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      ocnt_r <= CNT_W'(4);
      v_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SEED:   seed_r <= cfg_wdata;
          CFG_OCTAVE: ocnt_r <= cfg_wdata[CNT_W-1:0];
          default:    ;
        endcase
      end
      if (adv) begin
        v_r <= {v_r[PIPE_DEPTH-2:0], in_valid};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r      <= in_x_coord;
      z_r      <= in_z_coord;
      cnt_r[0] <= cnt_in;
      for (int i = 1; i < PIPE_DEPTH - 2; i++) begin
        cnt_r[i] <= cnt_r[i-1];
      end
    end
  end

  for (genvar o = 0; o < OCT_MAX; o++) begin : g_lane
    fvn_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .x    (x_r),
      .z    (z_r),
      .seed (seed_r),
      .octv (OCT_W'(o)),
      .n    (lane_n[o])
    );
  end

  fvn_norm u_norm (
    .clk   (clk),
    .adv   (adv),
    .n     (lane_n),
    .cnt   (cnt_r[PIPE_DEPTH-3]),
    .noise (out_noise_value)
  );

  assign out_valid = v_r[PIPE_DEPTH-1];

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v_r[PIPE_DEPTH-2]) |=> out_valid)
    else $error("beat lost in final stage");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[PIPE_DEPTH-3] != '0 && cnt_r[PIPE_DEPTH-3] <= CNT_W'(OCT_MAX)
    || !v_r[PIPE_DEPTH-3])
    else $error("octave count out of range in pipeline");
`endif

endmodule

[rtl/fvn_lane.sv]
module fvn_lane
  import fvn_pkg::*;
(
  input  logic             clk,
  input  logic             adv,
  input  logic [31:0]      x,
  input  logic [31:0]      z,
  input  logic [31:0]      seed,
  input  logic [OCT_W-1:0] octv,
  output logic [15:0]      n
);

  logic [63:0] x64, z64;
  logic [31:0] cx, cz, s;

  logic [31:0] pa_r, pb_r, pc_r, ttx_r, ttz_r;
  logic [15:0] tx_r, tz_r;
  logic [31:0] g_nxt [4];
  logic [31:0] g_r [4];
  logic [15:0] ux_r, uz_r;
  logic [31:0] m_r [4];
  logic [33:0] w_r [4];
  logic [48:0] p_r [4];
  logic [15:0] n_r;

  logic [31:0] h00;
  logic [49:0] smx, smz;
  logic [16:0] vx, vz;

  assign x64 = {{32{x[31]}}, x} << octv;
  assign z64 = {{32{z[31]}}, z} << octv;
  assign cx  = x64[47:16];
  assign cz  = z64[47:16];
  assign s   = seed + {{(32-OCT_W){1'b0}}, octv};

  assign h00 = pa_r + pb_r + pc_r;
  assign g_nxt[0] = h00 ^ (h00 >> 16);
  assign g_nxt[1] = (h00 + HASH_X) ^ ((h00 + HASH_X) >> 16);
  assign g_nxt[2] = (h00 + HASH_Z) ^ ((h00 + HASH_Z) >> 16);
  assign g_nxt[3] = (h00 + HASH_X + HASH_Z) ^ ((h00 + HASH_X + HASH_Z) >> 16);
  assign smx = {18'd0, ttx_r} * {32'd0, 18'd196608 - {1'b0, tx_r, 1'b0}};
  assign smz = {18'd0, ttz_r} * {32'd0, 18'd196608 - {1'b0, tz_r, 1'b0}};

  assign vx = 17'h10000 - {1'b0, ux_r};
  assign vz = 17'h10000 - {1'b0, uz_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r  <= cx * HASH_X;
      pb_r  <= cz * HASH_Z;
      pc_r  <= s * HASH_S;
      ttx_r <= {16'd0, x64[15:0]} * {16'd0, x64[15:0]};
      ttz_r <= {16'd0, z64[15:0]} * {16'd0, z64[15:0]};
      tx_r  <= x64[15:0];
      tz_r  <= z64[15:0];

      g_r  <= g_nxt;
      ux_r <= smx[47:32];
      uz_r <= smz[47:32];

      for (int k = 0; k < 4; k++) begin
        m_r[k] <= g_r[k] * HASH_MIX;
      end
      w_r[0] <= {17'd0, vx} * {17'd0, vz};
      w_r[1] <= {18'd0, ux_r} * {17'd0, vz};
      w_r[2] <= {17'd0, vx} * {18'd0, uz_r};
      w_r[3] <= {18'd0, ux_r} * {18'd0, uz_r};

      for (int k = 0; k < 4; k++) begin
        p_r[k] <= {33'd0, m_r[k][31:16]} * {15'd0, w_r[k]};
      end

      n_r <= 16'(({2'd0, p_r[0]} + {2'd0, p_r[1]} + {2'd0, p_r[2]} + {2'd0, p_r[3]}) >> 32);
    end
  end

  assign n = n_r;

endmodule

[rtl/fvn_norm.sv]
module fvn_norm
  import fvn_pkg::*;
(
  input  logic             clk,
  input  logic             adv,
  input  logic [15:0]      n [OCT_MAX],
  input  logic [CNT_W-1:0] cnt,
  output logic [15:0]      noise
);

  logic [ACC_W-1:0] acc_nxt, acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ACC_W+32:0] prod;
  logic [15:0] noise_r;

  always_comb begin
    acc_nxt = '0;
    for (int o = 0; o < OCT_MAX; o++) begin
      if (CNT_W'(o) < cnt) begin
        acc_nxt = acc_nxt +
          (ACC_W'(n[o]) << (cnt - CNT_W'(1) - CNT_W'(o)));
      end
    end
  end

  assign prod = {33'd0, acc_r} * {{ACC_W{1'b0}}, recip_lookup(cnt_r)};

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt;
      if (prod[ACC_W+32:48] != '0) begin
        noise_r <= 16'hffff;
      end else begin
        noise_r <= prod[47:32];
      end
    end
  end

  assign noise = noise_r;

endmodule
